@@ design/slru_pkg.sv @@
// Shared types and codes of the segmented LRU replacement engine.
package slru_pkg;

    localparam logic [2:0] KIND_NOT_FOUND = 3'd0;
    localparam logic [2:0] KIND_MISS_INSERTED = 3'd1;
    localparam logic [2:0] KIND_PROB_REFRESH = 3'd2;
    localparam logic [2:0] KIND_PROMOTED = 3'd3;
    localparam logic [2:0] KIND_PROT_REFRESH = 3'd4;
    localparam logic [2:0] KIND_EVICTION = 3'd5;

    localparam logic [2:0] REG_LIMIT_PROBATION = 3'd0;
    localparam logic [2:0] REG_LIMIT_PROTECTED = 3'd1;
    localparam logic [2:0] REG_SIZE_TYPE_A = 3'd2;
    localparam logic [2:0] REG_SIZE_TYPE_B = 3'd3;
    localparam logic [2:0] REG_SINGLE_POOL = 3'd4;

    localparam logic [1:0] RES_NONE = 2'd0;
    localparam logic [1:0] RES_PROBATION = 2'd1;
    localparam logic [1:0] RES_PROTECTED = 2'd2;

    typedef struct packed {
        logic [14:0] limit_probation;
        logic [14:0] limit_protected;
        logic [4:0]  size_type_a;
        logic [4:0]  size_type_b;
        logic        single_pool_only;
    } cfg_t;

    typedef struct packed {
        logic etype;
        logic present;
    } item_t;

    typedef struct packed {
        logic       strobe;
        logic [2:0] kind;
        logic [9:0] victim_index;
        logic       victim_type;
        logic       victim_segment;
        logic       last;
    } result_t;

endpackage

@@ design/slru_front.sv @@
// Front end: takes items, reduces the index into the table range, queues them.
module slru_front #(
    parameter int NUM_ENTRIES = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [9:0]                     entry_index,
    input  logic                           entry_type,
    input  logic                           entry_present,
    output logic                           busy,
    output logic                           q_valid,
    output logic [$clog2(NUM_ENTRIES)-1:0] q_idx,
    output slru_pkg::item_t                q_item,
    input  logic                           q_pop
);

    localparam int IW = $clog2(NUM_ENTRIES);
    // scaled reciprocal of the table size; exact quotient for any 10-bit index below 1024 entries
    localparam int RECIP = (NUM_ENTRIES >= 1024) ? 0 :
                           ((1 << 20) + NUM_ENTRIES - 1) / NUM_ENTRIES;

    function automatic logic [9:0] reduce_index(input logic [9:0] x);
        logic [29:0] prod;
        logic [19:0] qn;
        prod = 30'(x) * 30'(RECIP);
        qn = 20'(prod[29:20]) * 20'(NUM_ENTRIES);
        return (NUM_ENTRIES >= 1024) ? x : (x - qn[9:0]);
    endfunction

    logic            stage_full_reg, stage_full_next;
    logic [9:0]      rem_reg, rem_next;
    slru_pkg::item_t sitem_reg, sitem_next;

    logic [IW-1:0]   fidx_reg [2];
    slru_pkg::item_t fitem_reg [2];
    logic            wptr_reg, rptr_reg;
    logic [1:0]      fcount_reg;
    logic            push;

    assign busy = stage_full_reg;
    assign push = stage_full_reg && (fcount_reg != 2'd2);

    always_comb
    begin
        stage_full_next = stage_full_reg;
        rem_next = rem_reg;
        sitem_next = sitem_reg;
        if (!stage_full_reg && start)
        begin
            stage_full_next = 1'b1;
            rem_next = reduce_index(entry_index);
            sitem_next.etype = entry_type;
            sitem_next.present = entry_present;
        end
        else if (push)
        begin
            stage_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_full_reg <= 1'b0;
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fcount_reg <= 2'd0;
        end
        else
        begin
            stage_full_reg <= stage_full_next;
            if (push)
                wptr_reg <= ~wptr_reg;
            if (q_pop)
                rptr_reg <= ~rptr_reg;
            fcount_reg <= fcount_reg + 2'(push) - 2'(q_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sitem_reg <= sitem_next;
        if (push)
        begin
            fidx_reg[wptr_reg] <= IW'(rem_reg);
            fitem_reg[wptr_reg] <= sitem_reg;
        end
    end

    assign q_valid = (fcount_reg != 2'd0);
    assign q_idx = fidx_reg[rptr_reg];
    assign q_item = fitem_reg[rptr_reg];

endmodule

@@ design/slru_back.sv @@
// Back end: linked-list memories, segment heads, usage and the eviction sequencer.
module slru_back #(
    parameter int NUM_ENTRIES = 1024,
    parameter int MAX_SIZE_UNITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  slru_pkg::cfg_t                 cfg,
    input  logic                           q_valid,
    input  logic [$clog2(NUM_ENTRIES)-1:0] q_idx,
    input  slru_pkg::item_t                q_item,
    output logic                           q_pop,
    output slru_pkg::result_t              result
);

    localparam int IW = $clog2(NUM_ENTRIES);
    localparam int LW = $clog2(NUM_ENTRIES + 1);
    localparam int CW = $clog2(MAX_SIZE_UNITS + 1);
    localparam logic [LW-1:0] MARK = LW'(NUM_ENTRIES);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_DEC = 4'd2;
    localparam logic [3:0] ST_W1 = 4'd3;
    localparam logic [3:0] ST_W2 = 4'd4;
    localparam logic [3:0] ST_W3 = 4'd5;
    localparam logic [3:0] ST_CHK = 4'd6;
    localparam logic [3:0] ST_VRD = 4'd7;
    localparam logic [3:0] ST_VEX = 4'd8;

    localparam logic [1:0] OP_INS = 2'd0;
    localparam logic [1:0] OP_PRO = 2'd1;
    localparam logic [1:0] OP_RF0 = 2'd2;
    localparam logic [1:0] OP_RF1 = 2'd3;

    function automatic logic [5:0] charge(input logic [4:0] s);
        logic [5:0] c;
        c = {1'b0, s};
        if (c == 6'd0)
            c = 6'd1;
        if (int'(c) > MAX_SIZE_UNITS)
            c = 6'(MAX_SIZE_UNITS);
        return c;
    endfunction

    function automatic logic [14:0] u_add(input logic [14:0] u, input logic [5:0] s);
        logic [15:0] t;
        t = {1'b0, u} + 16'(s);
        return t[15] ? 15'h7FFF : t[14:0];
    endfunction

    function automatic logic [14:0] u_sub(input logic [14:0] u, input logic [5:0] s,
                                          input logic empty);
        logic [14:0] t;
        t = (u > 15'(s)) ? u - 15'(s) : 15'd0;
        return empty ? 15'd0 : t;
    endfunction

    logic [1:0]    res_mem [NUM_ENTRIES];
    logic          type_mem [NUM_ENTRIES];
    logic [LW-1:0] older_mem [NUM_ENTRIES];
    logic [LW-1:0] newer_mem [NUM_ENTRIES];

    logic [1:0]    res_q;
    logic          type_q;
    logic [LW-1:0] older_q, newer_q;
    logic [IW-1:0] rd_addr;

    logic          res_we, type_we, older_we, newer_we;
    logic [IW-1:0] res_wa, type_wa, older_wa, newer_wa;
    logic [1:0]    res_wd;
    logic          type_wd;
    logic [LW-1:0] older_wd, newer_wd;

    logic [3:0]    state_reg, state_next;
    logic [LW-1:0] clr_reg, clr_next;
    logic [IW-1:0] e_reg, e_next;
    logic [IW-1:0] victim_reg, victim_next;
    logic [LW-1:0] o_reg, o_next, n_reg, n_next, last_reg, last_next;
    logic          typ_reg, typ_next, pres_reg, pres_next;
    logic [1:0]    op_reg, op_next;
    logic          seg_reg, seg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [2:0]    pkind_reg, pkind_next;
    logic [IW-1:0] pvidx_reg, pvidx_next;
    logic          pvtype_reg, pvtype_next, pvseg_reg, pvseg_next;
    logic [LW-1:0] oldest_reg [2];
    logic [LW-1:0] oldest_next [2];
    logic [LW-1:0] newest_reg [2];
    logic [LW-1:0] newest_next [2];
    logic [14:0]   usage_reg [2];
    logic [14:0]   usage_next [2];
    slru_pkg::result_t out_reg, out_next;

    logic          src, dst, detach, refresh;
    logic [5:0]    sz;
    logic [14:0]   limit;
    logic [LW-1:0] e_ext;

    assign result = out_reg;
    assign limit = seg_reg ? cfg.limit_protected : cfg.limit_probation;

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        e_next = e_reg;
        victim_next = victim_reg;
        o_next = o_reg;
        n_next = n_reg;
        last_next = last_reg;
        typ_next = typ_reg;
        pres_next = pres_reg;
        op_next = op_reg;
        seg_next = seg_reg;
        cnt_next = cnt_reg;
        pkind_next = pkind_reg;
        pvidx_next = pvidx_reg;
        pvtype_next = pvtype_reg;
        pvseg_next = pvseg_reg;
        oldest_next = oldest_reg;
        newest_next = newest_reg;
        usage_next = usage_reg;
        out_next = '0;
        q_pop = 1'b0;
        rd_addr = e_reg;
        res_we = 1'b0;
        type_we = 1'b0;
        older_we = 1'b0;
        newer_we = 1'b0;
        res_wa = e_reg;
        type_wa = e_reg;
        older_wa = e_reg;
        newer_wa = e_reg;
        res_wd = slru_pkg::RES_NONE;
        type_wd = typ_reg;
        older_wd = last_reg;
        newer_wd = MARK;
        src = 1'b0;
        dst = 1'b0;
        sz = 6'd1;
        e_ext = LW'(e_reg);
        detach = (op_reg != OP_INS);
        refresh = (op_reg == OP_RF0) || (op_reg == OP_RF1);

        case (state_reg)
            ST_CLEAR:
            begin
                res_we = 1'b1;
                res_wa = clr_reg[IW-1:0];
                res_wd = slru_pkg::RES_NONE;
                clr_next = clr_reg + LW'(1);
                if (clr_reg == LW'(NUM_ENTRIES - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    rd_addr = q_idx;
                    e_next = q_idx;
                    typ_next = q_item.etype;
                    pres_next = q_item.present;
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                pvidx_next = '0;
                pvtype_next = 1'b0;
                pvseg_next = 1'b0;
                o_next = older_q;
                n_next = newer_q;
                if (!pres_reg)
                begin
                    out_next.strobe = 1'b1;
                    out_next.kind = slru_pkg::KIND_NOT_FOUND;
                    out_next.last = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    if (res_q == slru_pkg::RES_PROBATION && cfg.single_pool_only)
                    begin
                        op_next = OP_RF0;
                        pkind_next = slru_pkg::KIND_PROB_REFRESH;
                    end
                    else if (res_q == slru_pkg::RES_PROBATION)
                    begin
                        op_next = OP_PRO;
                        pkind_next = slru_pkg::KIND_PROMOTED;
                        src = 1'b0;
                        dst = 1'b1;
                    end
                    else if (res_q == slru_pkg::RES_PROTECTED)
                    begin
                        op_next = OP_RF1;
                        pkind_next = slru_pkg::KIND_PROT_REFRESH;
                        src = 1'b1;
                        dst = 1'b1;
                    end
                    else
                    begin
                        op_next = OP_INS;
                        pkind_next = slru_pkg::KIND_MISS_INSERTED;
                    end
                    seg_next = dst;
                    if (op_next != OP_INS)
                        typ_next = type_q;
                    if ((op_next == OP_RF0 || op_next == OP_RF1) && newest_reg[src] == e_ext)
                    begin
                        // already newest: nothing moves
                        out_next.strobe = 1'b1;
                        out_next.kind = pkind_next;
                        out_next.last = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        if (op_next != OP_INS)
                        begin
                            if (older_q >= MARK)
                                oldest_next[src] = newer_q;
                            if (newer_q >= MARK)
                                newest_next[src] = older_q;
                        end
                        last_next = newest_next[dst];
                        if (newest_next[dst] >= MARK)
                            oldest_next[dst] = e_ext;
                        newest_next[dst] = e_ext;
                        if (op_next == OP_PRO)
                        begin
                            sz = charge(type_q ? cfg.size_type_b : cfg.size_type_a);
                            usage_next[0] = u_sub(usage_reg[0], sz, oldest_next[0] >= MARK);
                            usage_next[1] = u_add(usage_reg[1], sz);
                        end
                        else if (op_next == OP_INS)
                        begin
                            sz = charge(typ_reg ? cfg.size_type_b : cfg.size_type_a);
                            usage_next[0] = u_add(usage_reg[0], sz);
                        end
                        state_next = ST_W1;
                    end
                end
            end
            ST_W1:
            begin
                newer_we = detach && (o_reg < MARK);
                newer_wa = o_reg[IW-1:0];
                newer_wd = n_reg;
                older_we = 1'b1;
                older_wa = e_reg;
                older_wd = last_reg;
                res_we = 1'b1;
                res_wa = e_reg;
                res_wd = (op_reg == OP_RF0 || op_reg == OP_INS) ?
                         slru_pkg::RES_PROBATION : slru_pkg::RES_PROTECTED;
                type_we = (op_reg == OP_INS);
                type_wa = e_reg;
                type_wd = typ_reg;
                state_next = ST_W2;
            end
            ST_W2:
            begin
                older_we = detach && (n_reg < MARK);
                older_wa = n_reg[IW-1:0];
                older_wd = o_reg;
                newer_we = (last_reg < MARK);
                newer_wa = last_reg[IW-1:0];
                newer_wd = e_ext;
                state_next = ST_W3;
            end
            ST_W3:
            begin
                newer_we = 1'b1;
                newer_wa = e_reg;
                newer_wd = MARK;
                cnt_next = '0;
                if (refresh)
                begin
                    out_next.strobe = 1'b1;
                    out_next.kind = pkind_reg;
                    out_next.last = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                if (usage_reg[seg_reg] > limit && int'(cnt_reg) < MAX_SIZE_UNITS &&
                    oldest_reg[seg_reg] < MARK)
                begin
                    state_next = ST_VRD;
                end
                else
                begin
                    // flush the held result as the final one
                    out_next.strobe = 1'b1;
                    out_next.kind = pkind_reg;
                    out_next.victim_index = 10'(pvidx_reg);
                    out_next.victim_type = pvtype_reg;
                    out_next.victim_segment = pvseg_reg;
                    out_next.last = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_VRD:
            begin
                rd_addr = oldest_reg[seg_reg][IW-1:0];
                victim_next = oldest_reg[seg_reg][IW-1:0];
                state_next = ST_VEX;
            end
            ST_VEX:
            begin
                if (older_q >= MARK)
                begin
                    oldest_next[seg_reg] = newer_q;
                end
                else
                begin
                    newer_we = 1'b1;
                    newer_wa = older_q[IW-1:0];
                    newer_wd = newer_q;
                end
                if (newer_q >= MARK)
                begin
                    newest_next[seg_reg] = older_q;
                end
                else
                begin
                    older_we = 1'b1;
                    older_wa = newer_q[IW-1:0];
                    older_wd = older_q;
                end
                res_we = 1'b1;
                res_wa = victim_reg;
                res_wd = slru_pkg::RES_NONE;
                sz = charge(type_q ? cfg.size_type_b : cfg.size_type_a);
                usage_next[seg_reg] = u_sub(usage_reg[seg_reg], sz,
                                            oldest_next[seg_reg] >= MARK);
                out_next.strobe = 1'b1;
                out_next.kind = pkind_reg;
                out_next.victim_index = 10'(pvidx_reg);
                out_next.victim_type = pvtype_reg;
                out_next.victim_segment = pvseg_reg;
                out_next.last = 1'b0;
                pkind_next = slru_pkg::KIND_EVICTION;
                pvidx_next = victim_reg;
                pvtype_next = type_q;
                pvseg_next = seg_reg;
                cnt_next = cnt_reg + CW'(1);
                state_next = ST_CHK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (res_we)
            res_mem[res_wa] <= res_wd;
        if (type_we)
            type_mem[type_wa] <= type_wd;
        if (older_we)
            older_mem[older_wa] <= older_wd;
        if (newer_we)
            newer_mem[newer_wa] <= newer_wd;
        res_q <= res_mem[rd_addr];
        type_q <= type_mem[rd_addr];
        older_q <= older_mem[rd_addr];
        newer_q <= newer_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            cnt_reg <= '0;
            oldest_reg[0] <= MARK;
            oldest_reg[1] <= MARK;
            newest_reg[0] <= MARK;
            newest_reg[1] <= MARK;
            usage_reg[0] <= 15'd0;
            usage_reg[1] <= 15'd0;
            out_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            cnt_reg <= cnt_next;
            oldest_reg <= oldest_next;
            newest_reg <= newest_next;
            usage_reg <= usage_next;
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg <= e_next;
        victim_reg <= victim_next;
        o_reg <= o_next;
        n_reg <= n_next;
        last_reg <= last_next;
        typ_reg <= typ_next;
        pres_reg <= pres_next;
        op_reg <= op_next;
        seg_reg <= seg_next;
        pkind_reg <= pkind_next;
        pvidx_reg <= pvidx_next;
        pvtype_reg <= pvtype_next;
        pvseg_reg <= pvseg_next;
    end

    a_empty_usage0: assert property (@(posedge clk) disable iff (!rst_n)
        (oldest_reg[0] == MARK) |-> (usage_reg[0] == 15'd0))
        else $error("empty probation segment with nonzero usage");
    a_empty_usage1: assert property (@(posedge clk) disable iff (!rst_n)
        (oldest_reg[1] == MARK) |-> (usage_reg[1] == 15'd0))
        else $error("empty protected segment with nonzero usage");
    a_heads0: assert property (@(posedge clk) disable iff (!rst_n)
        (oldest_reg[0] >= MARK) == (newest_reg[0] >= MARK))
        else $error("probation head and tail disagree on emptiness");
    a_evict_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(cnt_reg) <= MAX_SIZE_UNITS)
        else $error("eviction count above bound");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_next.strobe && out_next.last) |=> (state_reg == ST_IDLE))
        else $error("final result without return to idle");

endmodule

@@ design/segmented_lru_byte_budget_core.sv @@
// Top level of the two-segment LRU replacement engine with per-segment budgets.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------------
//  access   | start / busy          | entry_index, entry_type, entry_present
//  result   | strobe (no stall)     | kind, victim_index, victim_type, victim_segment, last
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// After reset the residency memory is cleared one entry at a time; items queue meanwhile.
// An access that is not found, or that refreshes the newest entry, ends in the decode
// state; a refresh that moves goes on through the link-write states, and an insertion or
// a promotion also through the budget check, plus a victim read and unlink per eviction.
// The front takes one item at a time into a two-entry queue; busy is high while
// it holds an item, which it keeps while the queue is full.
// Results appear one per strobe cycle; the receiver cannot stall them.
module segmented_lru_byte_budget_core #(
    parameter int NUM_ENTRIES = 1024,
    parameter int MAX_SIZE_UNITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [9:0]  entry_index,
    input  logic        entry_type,
    input  logic        entry_present,
    output logic        strobe,
    output logic [2:0]  kind,
    output logic [9:0]  victim_index,
    output logic        victim_type,
    output logic        victim_segment,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_data
);

    localparam int IW = $clog2(NUM_ENTRIES);

    slru_pkg::cfg_t    cfg_reg;
    slru_pkg::item_t   q_item;
    slru_pkg::result_t res;
    logic              q_valid, q_pop;
    logic [IW-1:0]     q_idx;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.limit_probation <= 15'd8192;
            cfg_reg.limit_protected <= 15'd8192;
            cfg_reg.size_type_a <= 5'd1;
            cfg_reg.size_type_b <= 5'd1;
            cfg_reg.single_pool_only <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                slru_pkg::REG_LIMIT_PROBATION: cfg_reg.limit_probation <= cfg_data;
                slru_pkg::REG_LIMIT_PROTECTED: cfg_reg.limit_protected <= cfg_data;
                slru_pkg::REG_SIZE_TYPE_A:     cfg_reg.size_type_a <= cfg_data[4:0];
                slru_pkg::REG_SIZE_TYPE_B:     cfg_reg.size_type_b <= cfg_data[4:0];
                slru_pkg::REG_SINGLE_POOL:     cfg_reg.single_pool_only <= cfg_data[0];
                default:                       cfg_reg <= cfg_reg;
            endcase
        end
    end

    slru_front #(
        .NUM_ENTRIES(NUM_ENTRIES)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .entry_index(entry_index),
        .entry_type(entry_type),
        .entry_present(entry_present),
        .busy(busy),
        .q_valid(q_valid),
        .q_idx(q_idx),
        .q_item(q_item),
        .q_pop(q_pop)
    );

    slru_back #(
        .NUM_ENTRIES(NUM_ENTRIES),
        .MAX_SIZE_UNITS(MAX_SIZE_UNITS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .q_valid(q_valid),
        .q_idx(q_idx),
        .q_item(q_item),
        .q_pop(q_pop),
        .result(res)
    );

    assign strobe = res.strobe;
    assign kind = res.kind;
    assign victim_index = res.victim_index;
    assign victim_type = res.victim_type;
    assign victim_segment = res.victim_segment;
    assign last = res.last;

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the two-segment LRU replacement engine.
`timescale 1ns / 100ps

module testbench;

    localparam int ENTRIES = 1024;
    localparam int MAX_UNITS = 16;
    localparam int NIL = ENTRIES;
    localparam int USAGE_CAP = 32767;
    localparam logic [2:0] KIND_UNCHECKED = 3'd7;

    typedef struct packed {
        logic [2:0] kind;
        logic [9:0] victim_index;
        logic       victim_type;
        logic       victim_segment;
        logic       last;
    } outcome_t;

    typedef struct {
        logic [9:0] idx;
        logic       etype;
        logic       present;
        logic       typed;
        logic [2:0] want_kind;
    } access_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [9:0]  entry_index;
    logic        entry_type;
    logic        entry_present;
    logic        strobe;
    logic [2:0]  kind;
    logic [9:0]  victim_index;
    logic        victim_type;
    logic        victim_segment;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [14:0] cfg_data;

    segmented_lru_byte_budget_core uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .entry_index(entry_index), .entry_type(entry_type), .entry_present(entry_present),
        .strobe(strobe), .kind(kind), .victim_index(victim_index),
        .victim_type(victim_type), .victim_segment(victim_segment), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // predictor state
    logic [1:0] resident [ENTRIES];
    logic       kept_type [ENTRIES];
    int         older [ENTRIES];
    int         newer [ENTRIES];
    int         seg_old [2];
    int         seg_new [2];
    int         seg_use [2];
    int         seg_limit [2];
    logic [4:0] units_a;
    logic [4:0] units_b;
    logic       single_pool;

    outcome_t   pending_results [$];
    logic [2:0] typed_kind [$];
    int         errors;
    bit         idle_enabled;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic int units_of(logic t);
        int s;
        s = int'(t ? units_b : units_a);
        if (s == 0) s = 1;
        if (s > MAX_UNITS) s = MAX_UNITS;
        return s;
    endfunction

    function automatic void unlink(int seg, int e);
        if (older[e] >= NIL) seg_old[seg] = newer[e];
        else newer[older[e]] = newer[e];
        if (newer[e] >= NIL) seg_new[seg] = older[e];
        else older[newer[e]] = older[e];
    endfunction

    function automatic void link_newest(int seg, int e);
        older[e] = seg_new[seg];
        newer[e] = NIL;
        if (seg_new[seg] >= NIL) seg_old[seg] = e;
        else newer[seg_new[seg]] = e;
        seg_new[seg] = e;
    endfunction

    function automatic void charge_seg(int seg, int s);
        seg_use[seg] = (seg_use[seg] + s > USAGE_CAP) ? USAGE_CAP : seg_use[seg] + s;
    endfunction

    function automatic void credit_seg(int seg, int s);
        seg_use[seg] = (seg_use[seg] > s) ? seg_use[seg] - s : 0;
        if (seg_old[seg] >= NIL) seg_use[seg] = 0;
    endfunction

    function automatic void trim_segment(int seg);
        int n;
        int v;
        outcome_t r;
        n = 0;
        while (seg_use[seg] > seg_limit[seg] && n < MAX_UNITS && seg_old[seg] < NIL) begin
            v = seg_old[seg];
            unlink(seg, v);
            resident[v] = slru_pkg::RES_NONE;
            credit_seg(seg, units_of(kept_type[v]));
            r.kind = slru_pkg::KIND_EVICTION;
            r.victim_index = v[9:0];
            r.victim_type = kept_type[v];
            r.victim_segment = seg[0];
            r.last = 1'b0;
            pending_results.push_back(r);
            n++;
        end
    endfunction

    function automatic void predict_access(logic [9:0] idx, logic t, logic present);
        int e;
        int s;
        int head;
        outcome_t r;
        e = int'(idx);
        head = pending_results.size();
        r = '0;
        pending_results.push_back(r);
        if (!present) begin
            r.kind = slru_pkg::KIND_NOT_FOUND;
        end else if (resident[e] == slru_pkg::RES_PROBATION) begin
            if (single_pool) begin
                if (seg_new[0] != e) begin
                    unlink(0, e);
                    link_newest(0, e);
                end
                r.kind = slru_pkg::KIND_PROB_REFRESH;
            end else begin
                s = units_of(kept_type[e]);
                unlink(0, e);
                credit_seg(0, s);
                link_newest(1, e);
                resident[e] = slru_pkg::RES_PROTECTED;
                charge_seg(1, s);
                r.kind = slru_pkg::KIND_PROMOTED;
            end
        end else if (resident[e] == slru_pkg::RES_PROTECTED) begin
            if (seg_new[1] != e) begin
                unlink(1, e);
                link_newest(1, e);
            end
            r.kind = slru_pkg::KIND_PROT_REFRESH;
        end else begin
            kept_type[e] = t;
            link_newest(0, e);
            resident[e] = slru_pkg::RES_PROBATION;
            charge_seg(0, units_of(t));
            r.kind = slru_pkg::KIND_MISS_INSERTED;
        end
        pending_results[head] = r;
        if (r.kind == slru_pkg::KIND_MISS_INSERTED) trim_segment(0);
        if (r.kind == slru_pkg::KIND_PROMOTED) trim_segment(1);
        r = pending_results[pending_results.size() - 1];
        r.last = 1'b1;
        pending_results[pending_results.size() - 1] = r;
    endfunction

    task automatic idle_gap();
        if (idle_enabled && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // start stays high into the next item unless an idle gap or a drain drops it
    task automatic send_access(logic [9:0] idx, logic t, logic present);
        idle_gap();
        predict_access(idx, t, present);
        start <= 1'b1;
        entry_index <= idx;
        entry_type <= t;
        entry_present <= present;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (pending_results.size() != 0 && guard < 200000) begin
            @(posedge clk);
            guard++;
        end
        if (pending_results.size() != 0) begin
            $display("%0t: expected %0d more results, actual none", $realtime,
                     pending_results.size());
            errors++;
        end
        // hold off a little before the next configuration write
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [14:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            slru_pkg::REG_LIMIT_PROBATION: seg_limit[0] = int'(data);
            slru_pkg::REG_LIMIT_PROTECTED: seg_limit[1] = int'(data);
            slru_pkg::REG_SIZE_TYPE_A:     units_a = data[4:0];
            slru_pkg::REG_SIZE_TYPE_B:     units_b = data[4:0];
            slru_pkg::REG_SINGLE_POOL:     single_pool = data[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // result checker
    always @(posedge clk) begin
        outcome_t got;
        outcome_t want;
        if (rst_n && strobe) begin
            got = {kind, victim_index, victim_type, victim_segment, last};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind=%0d victim=%0d",
                         $realtime, kind, victim_index);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected kind=%0d idx=%0d type=%0d seg=%0d last=%0d",
                             $realtime, want.kind, want.victim_index, want.victim_type,
                             want.victim_segment, want.last);
                    $display("%0t:          actual   kind=%0d idx=%0d type=%0d seg=%0d last=%0d",
                             $realtime, got.kind, got.victim_index, got.victim_type,
                             got.victim_segment, got.last);
                    errors++;
                end
            end
        end
    end

    // typed outcome check on directed rows that declare one
    always @(posedge clk) begin
        logic [2:0] k;
        if (rst_n && strobe && kind != slru_pkg::KIND_EVICTION && typed_kind.size() != 0) begin
            k = typed_kind.pop_front();
            if (k != KIND_UNCHECKED && k !== kind) begin
                $display("%0t: directed outcome expected %0d actual %0d", $realtime, k, kind);
                errors++;
            end
        end
    end

    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

    access_row_t directed [] = '{
        '{10'd0,    1'b0, 1'b0, 1'b1, slru_pkg::KIND_NOT_FOUND},
        '{10'd0,    1'b0, 1'b1, 1'b1, slru_pkg::KIND_MISS_INSERTED},
        '{10'd1023, 1'b1, 1'b1, 1'b1, slru_pkg::KIND_MISS_INSERTED},
        '{10'd0,    1'b1, 1'b1, 1'b1, slru_pkg::KIND_PROMOTED},
        '{10'd0,    1'b0, 1'b1, 1'b1, slru_pkg::KIND_PROT_REFRESH},
        '{10'd0,    1'b0, 1'b0, 1'b1, slru_pkg::KIND_NOT_FOUND},
        '{10'd1023, 1'b0, 1'b0, 1'b1, slru_pkg::KIND_NOT_FOUND},
        '{10'd512,  1'b1, 1'b1, 1'b0, slru_pkg::KIND_NOT_FOUND},
        '{10'd341,  1'b0, 1'b1, 1'b0, slru_pkg::KIND_NOT_FOUND},
        '{10'd682,  1'b1, 1'b1, 1'b0, slru_pkg::KIND_NOT_FOUND},
        '{10'd512,  1'b0, 1'b1, 1'b0, slru_pkg::KIND_NOT_FOUND},
        '{10'd1023, 1'b0, 1'b1, 1'b0, slru_pkg::KIND_NOT_FOUND},
        '{10'd341,  1'b0, 1'b1, 1'b0, slru_pkg::KIND_NOT_FOUND}
    };

    initial begin
        int phase;
        int n;
        int pool;
        logic [9:0] idx;
        errors = 0;
        idle_enabled = 1'b1;
        start = 1'b0;
        entry_index = '0;
        entry_type = 1'b0;
        entry_present = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = slru_pkg::REG_LIMIT_PROBATION;
        cfg_data = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            resident[i] = slru_pkg::RES_NONE;
            kept_type[i] = 1'b0;
            older[i] = 0;
            newer[i] = 0;
        end
        seg_old = '{NIL, NIL};
        seg_new = '{NIL, NIL};
        seg_use = '{0, 0};
        seg_limit = '{8192, 8192};
        units_a = 5'd1;
        units_b = 5'd1;
        single_pool = 1'b0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i]) begin
            typed_kind.push_back(directed[i].typed ? directed[i].want_kind : KIND_UNCHECKED);
            send_access(directed[i].idx, directed[i].etype, directed[i].present);
        end
        drain();
        // small budgets: hit the tiny-limit case, with the type size clamped to the unit bound
        write_reg(slru_pkg::REG_LIMIT_PROBATION, 15'd0);
        write_reg(slru_pkg::REG_SIZE_TYPE_B, 15'd31);
        send_access(10'd700, 1'b1, 1'b1);
        send_access(10'd700, 1'b1, 1'b1);
        drain();
        write_reg(slru_pkg::REG_LIMIT_PROBATION, 15'd40);
        write_reg(slru_pkg::REG_LIMIT_PROTECTED, 15'd0);
        send_access(10'd5, 1'b0, 1'b1);
        send_access(10'd5, 1'b0, 1'b1);
        drain();

        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    write_reg(slru_pkg::REG_LIMIT_PROBATION, 15'd12);
                    write_reg(slru_pkg::REG_LIMIT_PROTECTED, 15'd20);
                    write_reg(slru_pkg::REG_SIZE_TYPE_A, 15'd0);
                    write_reg(slru_pkg::REG_SIZE_TYPE_B, 15'd3);
                    write_reg(slru_pkg::REG_SINGLE_POOL, 15'd0);
                end
                1: begin
                    write_reg(slru_pkg::REG_SINGLE_POOL, 15'd1);
                    write_reg(slru_pkg::REG_SIZE_TYPE_A, 15'd16);
                    write_reg(slru_pkg::REG_LIMIT_PROBATION, 15'd40);
                end
                2: begin
                    write_reg(slru_pkg::REG_SINGLE_POOL, 15'd0);
                    write_reg(slru_pkg::REG_SIZE_TYPE_A, 15'd2);
                    write_reg(slru_pkg::REG_SIZE_TYPE_B, 15'd17);
                    write_reg(slru_pkg::REG_LIMIT_PROTECTED, 15'd5);
                end
                3: begin
                    write_reg(slru_pkg::REG_LIMIT_PROBATION, 15'd32767);
                    write_reg(slru_pkg::REG_LIMIT_PROTECTED, 15'd16384);
                    write_reg(slru_pkg::REG_SIZE_TYPE_B, 15'd1);
                end
                default: begin
                    // drop limits below usage so the eviction bound spreads work
                    write_reg(slru_pkg::REG_LIMIT_PROBATION, 15'd3);
                    write_reg(slru_pkg::REG_LIMIT_PROTECTED, 15'd2);
                    idle_enabled = 1'b0;
                end
            endcase
            pool = (phase == 3) ? 1023 : 24;
            for (n = 0; n < 19; n++) begin
                idx = 10'($urandom_range(0, pool));
                if (phase != 3 && $urandom_range(0, 9) == 0)
                    idx = 10'($urandom_range(0, 1023));
                send_access(idx, 1'($urandom_range(0, 1)), $urandom_range(0, 7) != 0);
            end
            drain();
        end

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

@@ filelist.f @@
design/slru_pkg.sv
design/slru_front.sv
design/slru_back.sv
design/segmented_lru_byte_budget_core.sv
sim/testbench.sv
